// ===== rtl/core/husc_pkg.sv =====
// shared constants and helpers for the hexagon / unit-square clipper
// no dependencies
package husc_pkg;

    localparam int MAX_VERTICES = 10;
    localparam int FRAC_BITS    = 16;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int EDGE_W       = FRAC_BITS + 18;

    // cos(30 deg) in Q0.30
    localparam logic [29:0] COS30_Q30 = 30'd929887697;

    // intersection offset limit and quotient width
    localparam int QUO_W = 41;

    // outcome codes
    localparam logic [1:0] OUT_CLIPPED = 2'd0;
    localparam logic [1:0] OUT_HEXAGON = 2'd1;
    localparam logic [1:0] OUT_SQUARE  = 2'd2;
    localparam logic [1:0] OUT_EMPTY   = 2'd3;

    // edge codes in clip order
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [1:0] SIDE_RIGHT  = 2'd2;
    localparam logic [1:0] SIDE_TOP    = 2'd3;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -48'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // inside test against one edge with tolerance
    function automatic logic inside_test(input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [EDGE_W-1:0] e,
                                         input logic [15:0] tol,
                                         input logic [1:0] side);
        logic signed [EDGE_W+1:0] px;
        logic signed [EDGE_W+1:0] py;
        logic signed [EDGE_W+1:0] lo;
        logic signed [EDGE_W+1:0] hi;
        logic r;
        px = (EDGE_W+2)'(x);
        py = (EDGE_W+2)'(y);
        lo = (EDGE_W+2)'(e) - $signed({{(EDGE_W-14){1'b0}}, tol});
        hi = (EDGE_W+2)'(e) + $signed({{(EDGE_W-14){1'b0}}, tol});
        r = 1'b0;
        unique case (side)
            SIDE_LEFT:   r = (px >= lo);
            SIDE_BOTTOM: r = (py <= hi);
            SIDE_RIGHT:  r = (px <= hi);
            SIDE_TOP:    r = (py >= lo);
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/hexagon_unit_square_clipper.sv =====
// hexagon / unit-square clipper top level: sequencer, vertex memories, mul/div unit
// depends on husc_pkg
//
// channel   direction  handshake                 payload
// command   in         start & !busy             square_col, square_row, hex_center_x/y, hex_radius
// config    in         cfg_valid & cfg_ready     cfg_data (tolerance)
// result    out        result_valid, one cycle   vertex_x, vertex_y, last, outcome
//
// one item at a time: the coefficient and build states make the hexagon; each clip pass reads
// the wrap vertex first, then reads, tests and may write each vertex; each intersection uses the
// shared bit-serial divider (setup, two multiply steps, range check, quotient bits, write), but
// takes the end point at once if near-parallel. an empty clip adds a check state, and the area
// pass when no edge rejects all; results go out one per cycle, the list behind a read register.
// reset clears control state and sets tolerance to 1; results cannot be stalled, cfg_ready high.
module hexagon_unit_square_clipper
    import husc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] square_col,
    input  logic signed [15:0] square_row,
    input  logic signed [31:0] hex_center_x,
    input  logic signed [31:0] hex_center_y,
    input  logic [23:0]        hex_radius,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    output logic               result_valid,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic               last,
    output logic [1:0]         outcome
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_COEF      = 5'd1;
    localparam logic [4:0] S_BUILD     = 5'd2;
    localparam logic [4:0] S_PREV_RD   = 5'd3;
    localparam logic [4:0] S_PREV_WAIT = 5'd4;
    localparam logic [4:0] S_CUR_RD    = 5'd5;
    localparam logic [4:0] S_CUR_EVAL  = 5'd6;
    localparam logic [4:0] S_XS        = 5'd7;
    localparam logic [4:0] S_MUL0      = 5'd8;
    localparam logic [4:0] S_MUL1      = 5'd9;
    localparam logic [4:0] S_DIVCHK    = 5'd10;
    localparam logic [4:0] S_DIV       = 5'd11;
    localparam logic [4:0] S_XFIN      = 5'd12;
    localparam logic [4:0] S_CURWR     = 5'd13;
    localparam logic [4:0] S_NEXT      = 5'd14;
    localparam logic [4:0] S_EMPTYCHK  = 5'd15;
    localparam logic [4:0] S_AREA_MUL  = 5'd16;
    localparam logic [4:0] S_AREA_ACC  = 5'd17;
    localparam logic [4:0] S_AREA_CMP  = 5'd18;
    localparam logic [4:0] S_OUT_LIST  = 5'd19;
    localparam logic [4:0] S_OUT_HEX   = 5'd20;
    localparam logic [4:0] S_OUT_SQ    = 5'd21;
    localparam logic [4:0] S_OUT_EMPTY = 5'd22;

    localparam logic [QUO_W-1:0] Q_LIM = QUO_W'(1) << (QUO_W - 1);
    localparam logic signed [67:0] AREA_LIM = 68'sd1 <<< (2 * FRAC_BITS + 1);

    // control state
    logic [4:0]        state_reg;
    logic [15:0]       tol_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  m_reg;
    logic [ADDR_W-1:0] i_reg;
    logic [1:0]        side_reg;
    logic              src_b_reg;
    logic [5:0]        cnt_reg;
    logic [3:0]        k_reg;
    logic [ADDR_W-1:0] issue_reg;
    logic              pend_reg;
    logic              pend_last_reg;
    logic              rv_reg;

    // payload registers
    logic signed [15:0] col_reg;
    logic signed [15:0] row_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic [23:0]        r_reg;
    logic [23:0]        a_reg;
    logic [3:0]         all_out_reg;
    logic signed [31:0] hex_x_reg [6];
    logic signed [31:0] hex_y_reg [6];
    logic signed [31:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic               prev_in_reg, cur_in_reg;
    logic [32:0]        mul_a_reg;
    logic [33:0]        mul_b_reg;
    logic [32:0]        div_d_reg;
    logic               neg_reg;
    logic [66:0]        prod_reg;
    logic [33:0]        rem_reg;
    logic [QUO_W-1:0]   low_reg;
    logic [QUO_W-1:0]   q_reg;
    logic signed [63:0] am_reg;
    logic               asub_reg;
    logic signed [67:0] acc_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic               last_reg;
    logic [1:0]         outcome_reg;

    // vertex lists, x in the upper word
    logic [63:0] mem_a [MAX_VERTICES];
    logic [63:0] mem_b [MAX_VERTICES];
    logic [63:0] rd_a_reg, rd_b_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [63:0]       wr_data;
    logic              wr_to_a;

    // square edges
    logic signed [EDGE_W-1:0] e0, e1, e2, e3, e_sel;
    logic signed [16:0] row_p1, col_p1;

    assign row_p1 = 17'(row_reg) + 17'sd1;
    assign col_p1 = 17'(col_reg) + 17'sd1;
    assign e0 = EDGE_W'($signed({col_reg, {FRAC_BITS{1'b0}}}));
    assign e1 = EDGE_W'($signed({row_p1, {FRAC_BITS{1'b0}}}));
    assign e2 = EDGE_W'($signed({col_p1, {FRAC_BITS{1'b0}}}));
    assign e3 = EDGE_W'($signed({row_reg, {FRAC_BITS{1'b0}}}));

    always_comb
    begin
        case (side_reg)
            SIDE_LEFT:   e_sel = e0;
            SIDE_BOTTOM: e_sel = e1;
            SIDE_RIGHT:  e_sel = e2;
            default:     e_sel = e3;
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign result_valid = rv_reg;
    assign vertex_x     = vx_reg;
    assign vertex_y     = vy_reg;
    assign last         = last_reg;
    assign outcome      = outcome_reg;

    // source list read data
    logic [63:0]        src_rd;
    logic signed [31:0] src_x, src_y;
    logic               src_in;

    assign src_rd = src_b_reg ? rd_b_reg : rd_a_reg;
    assign src_x  = $signed(src_rd[63:32]);
    assign src_y  = $signed(src_rd[31:0]);
    assign src_in = inside_test(src_x, src_y, e_sel, tol_reg, side_reg);

    // hexagon vertex under construction
    logic signed [33:0] a_s, h_s, r_s;
    logic signed [33:0] bx, by;
    logic signed [31:0] vtx_x, vtx_y;
    logic [24:0]        h_sum;

    assign h_sum = {1'b0, r_reg} + 25'd1;
    assign a_s = $signed({10'b0, a_reg});
    assign h_s = $signed({10'b0, h_sum[24:1]});
    assign r_s = $signed({10'b0, r_reg});

    always_comb
    begin
        case (k_reg)
            4'd0:    begin bx = 34'(cx_reg) + a_s; by = 34'(cy_reg) + h_s; end
            4'd1:    begin bx = 34'(cx_reg);       by = 34'(cy_reg) + r_s; end
            4'd2:    begin bx = 34'(cx_reg) - a_s; by = 34'(cy_reg) + h_s; end
            4'd3:    begin bx = 34'(cx_reg) - a_s; by = 34'(cy_reg) - h_s; end
            4'd4:    begin bx = 34'(cx_reg);       by = 34'(cy_reg) - r_s; end
            default: begin bx = 34'(cx_reg) + a_s; by = 34'(cy_reg) - h_s; end
        endcase
    end

    assign vtx_x = sat32(48'(bx));
    assign vtx_y = sat32(48'(by));

    // intersection setup from the stored segment
    logic               even_side;
    logic signed [34:0] dd, na, nb;
    logic [34:0]        ad, aa, ab;
    logic               par;
    logic signed [31:0] s_other;

    assign even_side = ~side_reg[0];

    always_comb
    begin
        if (even_side)
        begin
            dd = 35'(cur_x_reg) - 35'(prev_x_reg);
            na = 35'(cur_y_reg) - 35'(prev_y_reg);
            nb = 35'(e_sel) - 35'(prev_x_reg);
        end
        else
        begin
            dd = 35'(cur_y_reg) - 35'(prev_y_reg);
            na = 35'(cur_x_reg) - 35'(prev_x_reg);
            nb = 35'(e_sel) - 35'(prev_y_reg);
        end
    end

    assign ad  = dd[34] ? 35'(-dd) : 35'(dd);
    assign aa  = na[34] ? 35'(-na) : 35'(na);
    assign ab  = nb[34] ? 35'(-nb) : 35'(nb);
    assign par = (ad == 35'd0) || (ad < {19'd0, tol_reg});
    assign s_other = even_side ? prev_y_reg : prev_x_reg;

    // divider step
    logic [33:0] rem_shift;
    logic        rem_ge;

    assign rem_shift = {rem_reg[32:0], low_reg[QUO_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_d_reg});

    // finished intersection point
    logic [QUO_W-1:0]   q_lim;
    logic signed [43:0] q_s;
    logic signed [43:0] coord;
    logic signed [31:0] e_sat;
    logic [63:0]        xs_pt;

    assign q_lim = (q_reg > Q_LIM) ? Q_LIM : q_reg;
    assign q_s   = neg_reg ? -$signed({3'b0, q_lim}) : $signed({3'b0, q_lim});
    assign coord = 44'(s_other) + q_s;
    assign e_sat = sat32(48'(e_sel));
    assign xs_pt = even_side ? {e_sat, sat32(48'(coord))} : {sat32(48'(coord)), e_sat};

    // counts after a write
    logic [CNT_W-1:0] m_inc;
    assign m_inc = m_reg + CNT_W'(1);

    // memory port control
    always_comb
    begin
        rd_addr = i_reg;
        if (state_reg == S_PREV_RD)
            rd_addr = ADDR_W'(n_reg - CNT_W'(1));
        else if (state_reg == S_OUT_LIST)
            rd_addr = issue_reg;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = {cur_x_reg, cur_y_reg};
        wr_to_a = src_b_reg;
        case (state_reg)
            S_BUILD:
            begin
                wr_en   = 1'b1;
                wr_data = {vtx_x, vtx_y};
                wr_to_a = 1'b1;
            end
            S_XS:   wr_en = par;
            S_XFIN:
            begin
                wr_en   = 1'b1;
                wr_data = xs_pt;
            end
            S_CURWR: wr_en = 1'b1;
            default: wr_en = 1'b0;
        endcase
    end

    // vertex memories; a pass reads one list and writes the other, so no entry overlaps
    logic [ADDR_W-1:0] wr_addr;
    assign wr_addr = (state_reg == S_BUILD) ? ADDR_W'(k_reg) : ADDR_W'(m_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_to_a)
            mem_a[wr_addr] <= wr_data;
        if (wr_en && !wr_to_a)
            mem_b[wr_addr] <= wr_data;
        rd_a_reg <= mem_a[rd_addr];
        rd_b_reg <= mem_b[rd_addr];
    end

    // multiplier products: radius coefficient, intersection partial product, area term
    logic [53:0]  coef_prod;
    logic [50:0]  mul_part;
    logic signed [63:0] area_prod;

    assign coef_prod = r_reg * COS30_Q30 + 54'd536870912;
    assign mul_part  = mul_a_reg * (state_reg == S_MUL0 ? mul_b_reg[16:0] : mul_b_reg[33:17]);
    assign area_prod = asub_reg ? $signed(hex_x_reg[0]) * $signed(hex_y_reg[5])
                                : $signed(hex_x_reg[5]) * $signed(hex_y_reg[0]);

    // hexagon vertex inside flags for all edges
    logic [3:0] vtx_in;
    assign vtx_in[0] = inside_test(vtx_x, vtx_y, e0, tol_reg, SIDE_LEFT);
    assign vtx_in[1] = inside_test(vtx_x, vtx_y, e1, tol_reg, SIDE_BOTTOM);
    assign vtx_in[2] = inside_test(vtx_x, vtx_y, e2, tol_reg, SIDE_RIGHT);
    assign vtx_in[3] = inside_test(vtx_x, vtx_y, e3, tol_reg, SIDE_TOP);

    // square corners
    logic signed [31:0] sq_x, sq_y;
    always_comb
    begin
        case (k_reg)
            4'd0:    begin sq_x = sat32(48'(e0)); sq_y = sat32(48'(e3)); end
            4'd1:    begin sq_x = sat32(48'(e0)); sq_y = sat32(48'(e1)); end
            4'd2:    begin sq_x = sat32(48'(e2)); sq_y = sat32(48'(e1)); end
            default: begin sq_x = sat32(48'(e2)); sq_y = sat32(48'(e3)); end
        endcase
    end

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= 16'd1;
        else if (cfg_valid && cfg_ready)
            tol_reg <= cfg_data;
    end

    // hexagon ring: shift in during build, rotate during area and output
    always_ff @(posedge clk)
    begin
        if (state_reg == S_BUILD)
        begin
            for (int j = 0; j < 5; j++)
            begin
                hex_x_reg[j] <= hex_x_reg[j+1];
                hex_y_reg[j] <= hex_y_reg[j+1];
            end
            hex_x_reg[5] <= vtx_x;
            hex_y_reg[5] <= vtx_y;
        end
        else if ((state_reg == S_AREA_ACC && asub_reg) || state_reg == S_OUT_HEX)
        begin
            for (int j = 0; j < 5; j++)
            begin
                hex_x_reg[j] <= hex_x_reg[j+1];
                hex_y_reg[j] <= hex_y_reg[j+1];
            end
            hex_x_reg[5] <= hex_x_reg[0];
            hex_y_reg[5] <= hex_y_reg[0];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            m_reg         <= '0;
            i_reg         <= '0;
            side_reg      <= SIDE_LEFT;
            src_b_reg     <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            rv_reg   <= 1'b0;
            pend_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        col_reg   <= square_col;
                        row_reg   <= square_row;
                        cx_reg    <= hex_center_x;
                        cy_reg    <= hex_center_y;
                        r_reg     <= hex_radius;
                        state_reg <= S_COEF;
                    end
                end
                S_COEF:
                begin
                    a_reg       <= coef_prod[53:30];
                    k_reg       <= '0;
                    all_out_reg <= 4'b1111;
                    state_reg   <= S_BUILD;
                end
                S_BUILD:
                begin
                    all_out_reg <= all_out_reg & ~vtx_in;
                    k_reg       <= k_reg + 4'd1;
                    if (k_reg == 4'd5)
                    begin
                        n_reg     <= CNT_W'(6);
                        m_reg     <= '0;
                        i_reg     <= '0;
                        side_reg  <= SIDE_LEFT;
                        src_b_reg <= 1'b0;
                        state_reg <= S_PREV_RD;
                    end
                end
                S_PREV_RD:
                    state_reg <= S_PREV_WAIT;
                S_PREV_WAIT:
                begin
                    prev_x_reg  <= src_x;
                    prev_y_reg  <= src_y;
                    prev_in_reg <= src_in;
                    state_reg   <= S_CUR_RD;
                end
                S_CUR_RD:
                    state_reg <= S_CUR_EVAL;
                S_CUR_EVAL:
                begin
                    cur_x_reg  <= src_x;
                    cur_y_reg  <= src_y;
                    cur_in_reg <= src_in;
                    if (src_in != prev_in_reg && m_reg < CNT_W'(MAX_VERTICES))
                        state_reg <= S_XS;
                    else if (src_in && m_reg < CNT_W'(MAX_VERTICES))
                        state_reg <= S_CURWR;
                    else
                        state_reg <= S_NEXT;
                end
                S_XS:
                begin
                    mul_a_reg <= aa[32:0];
                    mul_b_reg <= ab[33:0];
                    div_d_reg <= ad[32:0];
                    neg_reg   <= dd[34] ^ na[34] ^ nb[34];
                    if (par)
                    begin
                        // near-parallel segment: take its end point
                        m_reg <= m_inc;
                        if (cur_in_reg && m_inc < CNT_W'(MAX_VERTICES))
                            state_reg <= S_CURWR;
                        else
                            state_reg <= S_NEXT;
                    end
                    else
                        state_reg <= S_MUL0;
                end
                S_MUL0:
                begin
                    prod_reg  <= 67'(mul_part);
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    prod_reg  <= prod_reg + (67'(mul_part) << 17);
                    state_reg <= S_DIVCHK;
                end
                S_DIVCHK:
                begin
                    // quotient at or above the limit doubled: clamp at once
                    if ({7'd0, prod_reg[66:QUO_W]} >= div_d_reg)
                    begin
                        q_reg     <= Q_LIM;
                        state_reg <= S_XFIN;
                    end
                    else
                    begin
                        rem_reg   <= {8'd0, prod_reg[66:QUO_W]};
                        low_reg   <= prod_reg[QUO_W-1:0];
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_ge ? rem_shift - {1'b0, div_d_reg} : rem_shift;
                    low_reg <= {low_reg[QUO_W-2:0], 1'b0};
                    q_reg   <= {q_reg[QUO_W-2:0], rem_ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(QUO_W - 1))
                        state_reg <= S_XFIN;
                end
                S_XFIN:
                begin
                    m_reg <= m_inc;
                    if (cur_in_reg && m_inc < CNT_W'(MAX_VERTICES))
                        state_reg <= S_CURWR;
                    else
                        state_reg <= S_NEXT;
                end
                S_CURWR:
                begin
                    m_reg     <= m_inc;
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    prev_x_reg  <= cur_x_reg;
                    prev_y_reg  <= cur_y_reg;
                    prev_in_reg <= cur_in_reg;
                    i_reg       <= i_reg + ADDR_W'(1);
                    if (CNT_W'(i_reg) + CNT_W'(1) < n_reg)
                        state_reg <= S_CUR_RD;
                    else
                    begin
                        // end of pass: swap lists
                        n_reg     <= m_reg;
                        m_reg     <= '0;
                        i_reg     <= '0;
                        src_b_reg <= ~src_b_reg;
                        side_reg  <= side_reg + 2'd1;
                        if (m_reg == '0)
                            state_reg <= S_EMPTYCHK;
                        else if (side_reg == SIDE_TOP)
                        begin
                            issue_reg <= '0;
                            state_reg <= S_OUT_LIST;
                        end
                        else
                            state_reg <= S_PREV_RD;
                    end
                end
                S_EMPTYCHK:
                begin
                    k_reg <= '0;
                    if (all_out_reg != 4'b0000)
                        state_reg <= S_OUT_EMPTY;
                    else
                    begin
                        acc_reg   <= '0;
                        asub_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= S_AREA_MUL;
                    end
                end
                S_AREA_MUL:
                begin
                    am_reg    <= area_prod;
                    state_reg <= S_AREA_ACC;
                end
                S_AREA_ACC:
                begin
                    acc_reg  <= asub_reg ? acc_reg - 68'(am_reg) : acc_reg + 68'(am_reg);
                    asub_reg <= ~asub_reg;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd11)
                        state_reg <= S_AREA_CMP;
                    else
                        state_reg <= S_AREA_MUL;
                end
                S_AREA_CMP:
                begin
                    k_reg <= '0;
                    if (acc_reg < AREA_LIM && acc_reg > -AREA_LIM)
                        state_reg <= S_OUT_HEX;
                    else
                        state_reg <= S_OUT_SQ;
                end
                S_OUT_LIST:
                begin
                    // list read pipeline: address, data, result register
                    if (CNT_W'(issue_reg) < n_reg)
                    begin
                        pend_reg      <= 1'b1;
                        pend_last_reg <= (CNT_W'(issue_reg) + CNT_W'(1) == n_reg);
                        issue_reg     <= issue_reg + ADDR_W'(1);
                    end
                    if (pend_reg)
                    begin
                        rv_reg      <= 1'b1;
                        vx_reg      <= src_x;
                        vy_reg      <= src_y;
                        last_reg    <= pend_last_reg;
                        outcome_reg <= OUT_CLIPPED;
                        if (pend_last_reg)
                            state_reg <= S_IDLE;
                    end
                end
                S_OUT_HEX:
                begin
                    rv_reg      <= 1'b1;
                    vx_reg      <= hex_x_reg[0];
                    vy_reg      <= hex_y_reg[0];
                    last_reg    <= (k_reg == 4'd5);
                    outcome_reg <= OUT_HEXAGON;
                    k_reg       <= k_reg + 4'd1;
                    if (k_reg == 4'd5)
                        state_reg <= S_IDLE;
                end
                S_OUT_SQ:
                begin
                    rv_reg      <= 1'b1;
                    vx_reg      <= sq_x;
                    vy_reg      <= sq_y;
                    last_reg    <= (k_reg == 4'd3);
                    outcome_reg <= OUT_SQUARE;
                    k_reg       <= k_reg + 4'd1;
                    if (k_reg == 4'd3)
                        state_reg <= S_IDLE;
                end
                S_OUT_EMPTY:
                begin
                    rv_reg      <= 1'b1;
                    vx_reg      <= '0;
                    vy_reg      <= '0;
                    last_reg    <= 1'b1;
                    outcome_reg <= OUT_EMPTY;
                    state_reg   <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for hexagon_unit_square_clipper: a scoreboard class predicts
// the vertex stream (clipped list, hexagon, square or empty) of every accepted command; plain tasks drive the block
// depends on husc_pkg and the rtl top level
`timescale 1ns / 1ps

import husc_pkg::*;

typedef struct {
    int x;
    int y;
} point_t;

typedef struct {
    int       x;
    int       y;
    bit       fin;
    bit [1:0] kind;
} vertex_out_t;

class clip_scoreboard;
    longint unsigned tol = 1;
    longint edge_at[4];
    vertex_out_t pending[$];
    int errors = 0;

    function point_t mkpt(longint x, longint y);
        point_t p;
        p.x = int'((x > 64'sd2147483647) ? 64'sh7FFFFFFF
                 : (x < -64'sd2147483648) ? -64'sd2147483648 : x);
        p.y = int'((y > 64'sd2147483647) ? 64'sh7FFFFFFF
                 : (y < -64'sd2147483648) ? -64'sd2147483648 : y);
        return p;
    endfunction

    // a*b/d truncated toward zero, magnitude limited to 2^40
    function longint scaled_offset(longint a, longint b, longint d);
        bit neg;
        logic [63:0] ua, ub, ud, q;
        logic [127:0] prod;
        logic [63:0] lim;
        lim = 64'd1 << 40;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        if (d < 0) begin
            neg = !neg;
            ud = -d;
        end
        else
            ud = d;
        if (ud == 0)
            return 0;
        prod = {64'd0, ua} * {64'd0, ub};
        if (prod[127:64] >= ud)
            q = lim;
        else begin
            q = 64'(prod / {64'd0, ud});
            if (q > lim)
                q = lim;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function bit in_side(point_t p, int side);
        longint t;
        t = tol;
        case (side)
            SIDE_LEFT:   return longint'(p.x) >= edge_at[0] - t;
            SIDE_BOTTOM: return longint'(p.y) <= edge_at[1] + t;
            SIDE_RIGHT:  return longint'(p.x) <= edge_at[2] + t;
            default:     return longint'(p.y) >= edge_at[3] - t;
        endcase
    endfunction

    function point_t crossing(point_t s, point_t f, int side);
        longint e, d, ad;
        e = edge_at[side];
        if (side % 2 == 0) begin
            d = longint'(f.x) - s.x;
            ad = d < 0 ? -d : d;
            if (ad == 0 || ad < longint'(tol))
                return f;
            return mkpt(e, longint'(s.y) + scaled_offset(longint'(f.y) - s.y, e - s.x, d));
        end
        d = longint'(f.y) - s.y;
        ad = d < 0 ? -d : d;
        if (ad == 0 || ad < longint'(tol))
            return f;
        return mkpt(longint'(s.x) + scaled_offset(longint'(f.x) - s.x, e - s.y, d), e);
    endfunction

    function void push(point_t p, bit fin, bit [1:0] kind);
        vertex_out_t v;
        v.x = p.x;
        v.y = p.y;
        v.fin = fin;
        v.kind = kind;
        pending.push_back(v);
    endfunction

    // predict all vertices caused by one accepted command
    function void note_command(shortint col, shortint row, int cx, int cy, bit [23:0] rad);
        longint one, r, a, h;
        point_t hexv[6];
        point_t cur[$];
        point_t nxt[$];
        point_t prv;
        bit ci, pi;
        bit all_out[4];
        logic signed [127:0] acc;
        one = 64'sd1 << FRAC_BITS;
        r = rad;
        a = (r * longint'(COS30_Q30) + (64'sd1 << 29)) >>> 30;
        h = (r + 1) >>> 1;
        edge_at[0] = longint'(col) * one;
        edge_at[1] = (longint'(row) + 1) * one;
        edge_at[2] = (longint'(col) + 1) * one;
        edge_at[3] = longint'(row) * one;
        hexv[0] = mkpt(longint'(cx) + a, longint'(cy) + h);
        hexv[1] = mkpt(cx, longint'(cy) + r);
        hexv[2] = mkpt(longint'(cx) - a, longint'(cy) + h);
        hexv[3] = mkpt(longint'(cx) - a, longint'(cy) - h);
        hexv[4] = mkpt(cx, longint'(cy) - r);
        hexv[5] = mkpt(longint'(cx) + a, longint'(cy) - h);
        foreach (hexv[i])
            cur.push_back(hexv[i]);
        // four clip passes, list capped at MAX_VERTICES
        for (int side = 0; side < 4; side++) begin
            nxt.delete();
            prv = cur[cur.size() - 1];
            foreach (cur[i]) begin
                ci = in_side(cur[i], side);
                pi = in_side(prv, side);
                if (ci) begin
                    if (!pi && nxt.size() < MAX_VERTICES)
                        nxt.push_back(crossing(prv, cur[i], side));
                    if (nxt.size() < MAX_VERTICES)
                        nxt.push_back(cur[i]);
                end
                else if (pi && nxt.size() < MAX_VERTICES)
                    nxt.push_back(crossing(prv, cur[i], side));
                prv = cur[i];
            end
            cur = nxt;
            if (cur.size() == 0)
                break;
        end
        if (cur.size() > 0) begin
            foreach (cur[k])
                push(cur[k], k == cur.size() - 1, OUT_CLIPPED);
            return;
        end
        // nothing left: empty, whole hexagon or whole square
        all_out = '{1, 1, 1, 1};
        for (int i = 0; i < 6; i++)
            for (int s = 0; s < 4; s++)
                if (in_side(hexv[i], s))
                    all_out[s] = 0;
        if (all_out[0] || all_out[1] || all_out[2] || all_out[3]) begin
            push(mkpt(0, 0), 1, OUT_EMPTY);
            return;
        end
        acc = 0;
        for (int i = 0; i < 6; i++) begin
            acc = acc + longint'(hexv[(i + 5) % 6].x) * longint'(hexv[i].y);
            acc = acc - longint'(hexv[i].x) * longint'(hexv[(i + 5) % 6].y);
        end
        if (acc < 0)
            acc = -acc;
        if (acc < (128'sd1 << (2 * FRAC_BITS + 1))) begin
            for (int k = 0; k < 6; k++)
                push(hexv[k], k == 5, OUT_HEXAGON);
            return;
        end
        push(mkpt(edge_at[0], edge_at[3]), 0, OUT_SQUARE);
        push(mkpt(edge_at[0], edge_at[1]), 0, OUT_SQUARE);
        push(mkpt(edge_at[2], edge_at[1]), 0, OUT_SQUARE);
        push(mkpt(edge_at[2], edge_at[3]), 1, OUT_SQUARE);
    endfunction

    function void check_vertex(int x, int y, bit fin, bit [1:0] kind);
        vertex_out_t e;
        if (pending.size() == 0) begin
            $error("unexpected vertex x=%0d y=%0d", x, y);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e.x != x) begin
            $error("vertex_x expected %0d actual %0d", e.x, x);
            errors++;
        end
        if (e.y != y) begin
            $error("vertex_y expected %0d actual %0d", e.y, y);
            errors++;
        end
        if (e.fin != fin) begin
            $error("last expected %0d actual %0d", e.fin, fin);
            errors++;
        end
        if (e.kind != kind) begin
            $error("outcome expected %0d actual %0d", e.kind, kind);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int LIMIT = 10000000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [15:0] square_col = 0;
    logic signed [15:0] square_row = 0;
    logic signed [31:0] hex_center_x = 0;
    logic signed [31:0] hex_center_y = 0;
    logic [23:0]        hex_radius = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = 0;
    logic               result_valid;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last;
    logic [1:0]         outcome;

    clip_scoreboard sb = new();
    int cycles = 0;

    hexagon_unit_square_clipper dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .square_col(square_col), .square_row(square_row),
        .hex_center_x(hex_center_x), .hex_center_y(hex_center_y),
        .hex_radius(hex_radius), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .result_valid(result_valid), .vertex_x(vertex_x),
        .vertex_y(vertex_y), .last(last), .outcome(outcome)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // result monitor, one vertex transaction per strobe
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_vertex(vertex_x, vertex_y, last, outcome);
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // one command transaction, start stays high across back-to-back commands
    task automatic send_command(shortint col, shortint row, int cx, int cy, bit [23:0] r);
        int gap;
        square_col <= col;
        square_row <= row;
        hex_center_x <= cx;
        hex_center_y <= cy;
        hex_radius <= r;
        start <= 1;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(col, row, cx, cy, r);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_tolerance(bit [15:0] v);
        cfg_data <= v;
        cfg_valid <= 1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.tol = v;
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // random command: mostly a hexagon near its square, sometimes anything
    task automatic random_command();
        shortint col, row;
        int cx, cy;
        bit [23:0] r;
        col = shortint'($urandom);
        row = shortint'($urandom);
        if ($urandom_range(9) < 8) begin
            if ($urandom_range(3) == 0) begin
                col = shortint'(int'($urandom_range(0, 8)) - 4);
                row = shortint'(int'($urandom_range(0, 8)) - 4);
            end
            cx = int'(col) * 65536 + int'($urandom_range(0, 262143)) - 98304;
            cy = int'(row) * 65536 + int'($urandom_range(0, 262143)) - 98304;
            r = ($urandom_range(3) == 0) ? 24'($urandom_range(0, 16777215))
                                         : 24'($urandom_range(0, 131071));
        end
        else begin
            cx = $urandom;
            cy = $urandom;
            r = 24'($urandom);
        end
        send_command(col, row, cx, cy, r);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            // let the pipeline empty out once mid-phase
            if (i == n / 2)
                drain();
            random_command();
        end
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        repeat (3) @(posedge clk);

        // directed: reset tolerance
        send_command(0, 0, 32768, 32768, 16384);           // fully inside
        send_command(0, 0, 32768, 32768, 24'hFFFFFF);      // covers the square
        send_command(0, 0, 32768, 32768, 0);               // degenerate point
        send_command(0, 0, 400000, 32768, 10000);          // outside right: empty
        send_command(0, 0, -300000, 32768, 10000);         // outside left: empty
        send_command(0, 0, 32768, 300000, 10000);          // outside bottom
        send_command(0, 0, 32768, -300000, 10000);         // outside top
        send_command(0, 0, 0, 0, 40000);                   // straddles a corner
        send_command(0, 0, 70000, 70000, 5000);            // small, past a corner
        send_command(0, 0, 32768, 32768, 40000);           // cut on all edges
        send_command(-32768, -32768, 32'sh80000000, 32'sh80000000, 24'hFFFFFF);
        send_command(32767, 32767, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF);
        send_command(32767, -32768, 32'sh7FFFF000, 32'sh80001000, 100000);
        send_command(-32768, 32767, 32'sh80000000, 32'sh7FFFFFFF, 65536);
        send_command(5, -7, 5 * 65536 + 32768, -7 * 65536 + 32768, 46000);
        drain();

        // tolerance zero and wide, parallel segments within tolerance
        write_tolerance(0);
        send_command(0, 0, 32768, 32768, 40000);
        send_command(0, 0, 0, 32768, 30000);
        send_command(0, 0, 70000, 70000, 5000);
        drain();
        write_tolerance(16'hFFFF);
        send_command(0, 0, 32768, 32768, 40000);
        send_command(0, 0, 0, 0, 40000);
        send_command(0, 0, 140000, 32768, 10000);
        send_command(0, 0, 32768, 32768, 60000);
        drain();

        // random phases across settings
        write_tolerance(1);
        random_phase(120);
        write_tolerance(0);
        random_phase(90);
        write_tolerance(16'hFFFF);
        random_phase(90);
        write_tolerance(16'($urandom));
        random_phase(90);
        write_tolerance(16'($urandom_range(0, 255)));
        random_phase(90);

        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/husc_pkg.sv
rtl/core/hexagon_unit_square_clipper.sv
tb/testbench.sv
